// ===== hw/rtl/tfq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfq_pkg
// Shared types and constants for the time-qualified threshold flag.
// ----------------------------------------------------------------------------
package tfq_pkg;

    localparam int unsigned TS_W   = 48;
    localparam int unsigned LVL_W  = 32;
    localparam int unsigned TIME_W = 32;
    localparam int unsigned CODE_W = 6;
    localparam int unsigned ADDR_W = 3;

    localparam logic [TS_W-1:0] LOG_TIME_MASK = 48'h7FFF_FFFF_FFFF;
    localparam logic [TS_W-1:0] LOG_ACT_MARK  = 48'h8000_0000_0000;

    localparam logic [ADDR_W-1:0] REG_TRIGGER_LEVEL = 3'd0;
    localparam logic [ADDR_W-1:0] REG_RESET_LEVEL   = 3'd1;
    localparam logic [ADDR_W-1:0] REG_HYST_TIME     = 3'd2;
    localparam logic [ADDR_W-1:0] REG_HOLD_TIME     = 3'd3;
    localparam logic [ADDR_W-1:0] REG_FLAG_MODE     = 3'd4;
    localparam logic [ADDR_W-1:0] REG_LOG_ARMED     = 3'd5;
    localparam logic [ADDR_W-1:0] REG_ALARM_ID      = 3'd6;

    localparam logic [1:0] MODE_DISABLED  = 2'd0;
    localparam logic [1:0] MODE_LOG       = 2'd1;
    localparam logic [1:0] MODE_LOG_RELAY = 2'd2;

    typedef enum logic [1:0] {
        ST_INACTIVE   = 2'd0,
        ST_ACT_PEND   = 2'd1,
        ST_ACTIVE     = 2'd2,
        ST_INACT_PEND = 2'd3
    } alarm_state_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_ACT   = 2'd1,
        EV_DEACT = 2'd2
    } log_event_t;

    typedef struct packed {
        logic signed [LVL_W-1:0] trigger_level;
        logic signed [LVL_W-1:0] reset_level;
        logic [TIME_W-1:0]       hyst_time;
        logic [TIME_W-1:0]       hold_time;
        logic [1:0]              flag_mode;
        logic                    log_armed;
        logic [CODE_W-1:0]       alarm_id;
    } cfg_t;

    typedef struct packed {
        alarm_state_t    alarm_st;
        logic [TS_W-1:0] phase_start;
        logic            held_flag_bit;
        logic            held_relay_bit;
    } flag_ctx_t;

    typedef struct packed {
        logic              flag_bit;
        logic              relay_bit;
        log_event_t        log_event;
        logic [TS_W-1:0]   log_word;
        logic [CODE_W-1:0] log_id;
        alarm_state_t      state_now;
        logic              changed;
    } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/threshold_flag_time_qualifier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_flag_time_qualifier
// Hysteresis threshold detector with time-qualified state changes.
//
// Input channel: in_valid / in_stall carry sample_value and timestamp.
// Output channel: out_valid / out_stall carry one result per sample:
// flag_bit, relay_bit, log_event, log_word, log_id, state_now, changed.
// Registers are written through cfg_we / cfg_addr / cfg_wdata while idle;
// the user must keep to this, the block does not enforce it. A transaction
// is accepted when valid is high and stall is low. An accepted sample is
// captured in the input register, evaluated against the flag state and
// registered on the outputs when they can advance. Throughput is one sample
// per cycle while the receiver does not stall; the state machine, the phase
// timer adds and the threshold compares are all combinational. When the
// receiver stalls the result holds, the input register still takes one more
// sample, and in_stall rises once both registers are occupied. Reset clears
// the config, valid bits, flag state (inactive), phase start and held output
// bits; the sample, timestamp and result registers are not reset.
module threshold_flag_time_qualifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic signed [31:0] sample_value,
    input  wire logic [47:0] timestamp,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             flag_bit,
    output logic             relay_bit,
    output logic [1:0]       log_event,
    output logic [47:0]      log_word,
    output logic [5:0]       log_id,
    output logic [1:0]       state_now,
    output logic             changed
);
    import tfq_pkg::*;

    cfg_t               cfg_reg;
    flag_ctx_t          ctx_reg;
    flag_ctx_t          ctx_next;
    result_t            res_reg;
    result_t            res_next;
    logic               in_vld_reg;
    logic signed [31:0] sample_reg;
    logic [TS_W-1:0]    ts_reg;
    logic               out_vld_reg;
    logic               advance;
    logic               in_take;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_TRIGGER_LEVEL: cfg_reg.trigger_level <= cfg_wdata;
                REG_RESET_LEVEL:   cfg_reg.reset_level   <= cfg_wdata;
                REG_HYST_TIME:     cfg_reg.hyst_time     <= cfg_wdata;
                REG_HOLD_TIME:     cfg_reg.hold_time     <= cfg_wdata;
                REG_FLAG_MODE:     cfg_reg.flag_mode     <= cfg_wdata[1:0];
                REG_LOG_ARMED:     cfg_reg.log_armed     <= cfg_wdata[0];
                REG_ALARM_ID:      cfg_reg.alarm_id      <= cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    tfq_step u_step (
        .cfg          (cfg_reg),
        .ctx          (ctx_reg),
        .sample_value (sample_reg),
        .timestamp    (ts_reg),
        .ctx_next     (ctx_next),
        .res          (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            ctx_reg     <= '{alarm_st: ST_INACTIVE, phase_start: '0,
                             held_flag_bit: 1'b0, held_relay_bit: 1'b0};
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;
            if (advance)
            begin
                out_vld_reg <= 1'b1;
                ctx_reg     <= ctx_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample_value;
            ts_reg     <= timestamp;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = out_vld_reg;
    assign flag_bit  = res_reg.flag_bit;
    assign relay_bit = res_reg.relay_bit;
    assign log_event = res_reg.log_event;
    assign log_word  = res_reg.log_word;
    assign log_id    = res_reg.log_id;
    assign state_now = res_reg.state_now;
    assign changed   = res_reg.changed;

    a_changed_settled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && changed) |->
            (state_now == ST_ACTIVE || state_now == ST_INACTIVE ||
             state_now == ST_INACT_PEND))
        else $error("confirmation reported with a pending-only state");

    a_log_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && log_event != EV_NONE) |-> changed)
        else $error("log transaction without a confirmed transition");

    a_relay_implies_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && relay_bit) |-> flag_bit)
        else $error("relay driven while flag is clear");

    a_state_tracks_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> (state_now == ctx_reg.alarm_st))
        else $error("result state differs from stored flag state");

endmodule
`default_nettype wire

// ===== hw/rtl/tfq_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tfq_step
// Next-state and result logic for one sample of the threshold flag machine.
// ----------------------------------------------------------------------------
module tfq_step (
    input  var tfq_pkg::cfg_t      cfg,
    input  var tfq_pkg::flag_ctx_t ctx,
    input  var logic signed [31:0] sample_value,
    input  var logic [47:0]        timestamp,
    output tfq_pkg::flag_ctx_t     ctx_next,
    output tfq_pkg::result_t       res
);
    import tfq_pkg::*;

    logic [TS_W:0]   ts_ext;
    logic [TS_W:0]   hyst_end;
    logic [TS_W:0]   hold_end;
    logic            run;
    logic            rising;
    logic            trig_hit;
    logic            rst_hit;
    logic            hyst_ok;
    alarm_state_t    st;
    logic [TS_W-1:0] ps;
    logic            chg;
    log_event_t      ev;
    logic [TS_W-1:0] word;
    logic            flag_b;
    logic            relay_b;

    assign ts_ext   = {1'b0, timestamp};
    assign hyst_end = {1'b0, ctx.phase_start} + {{(TS_W+1-TIME_W){1'b0}}, cfg.hyst_time};
    assign hold_end = {1'b0, ctx.phase_start} + {{(TS_W+1-TIME_W){1'b0}}, cfg.hold_time};
    assign hyst_ok  = (ts_ext >= hyst_end);

    assign rising   = (cfg.trigger_level >= cfg.reset_level);
    assign trig_hit = rising ? (sample_value >= cfg.trigger_level)
                             : (sample_value <= cfg.trigger_level);
    assign rst_hit  = rising ? (sample_value <= cfg.reset_level)
                             : (sample_value >= cfg.reset_level);

    assign run = (cfg.flag_mode != MODE_DISABLED) &&
                 !((cfg.hold_time != '0) && (ctx.alarm_st == ST_ACTIVE) &&
                   (ts_ext < hold_end));

    always_comb
    begin
        st      = ctx.alarm_st;
        ps      = ctx.phase_start;
        chg     = 1'b0;
        ev      = EV_NONE;
        word    = '0;
        flag_b  = ctx.held_flag_bit;
        relay_b = ctx.held_relay_bit;
        if (run)
        begin
            if (trig_hit)
            begin
                if (st == ST_INACTIVE || st == ST_INACT_PEND)
                begin
                    st = ST_ACT_PEND;
                    ps = timestamp;
                end
                else if (st == ST_ACT_PEND && hyst_ok)
                begin
                    st  = ST_ACTIVE;
                    chg = 1'b1;
                    if (cfg.log_armed)
                    begin
                        ev   = EV_ACT;
                        word = (timestamp & LOG_TIME_MASK) | LOG_ACT_MARK;
                    end
                end
            end
            // phase_start is untouched above whenever st is still INACT_PEND here
            if (rst_hit)
            begin
                if (st == ST_ACTIVE || st == ST_ACT_PEND)
                begin
                    st = ST_INACT_PEND;
                    ps = timestamp;
                end
                else if (st == ST_INACT_PEND && hyst_ok)
                begin
                    st  = ST_INACTIVE;
                    chg = 1'b1;
                    if (cfg.log_armed)
                    begin
                        ev   = EV_DEACT;
                        word = timestamp & LOG_TIME_MASK;
                    end
                end
            end
            flag_b  = (st == ST_ACTIVE) || (st == ST_INACT_PEND);
            relay_b = flag_b && (cfg.flag_mode == MODE_LOG_RELAY);
        end
    end

    always_comb
    begin
        ctx_next.alarm_st       = st;
        ctx_next.phase_start    = ps;
        ctx_next.held_flag_bit  = flag_b;
        ctx_next.held_relay_bit = relay_b;
        res.flag_bit  = flag_b;
        res.relay_bit = relay_b;
        res.log_event = ev;
        res.log_word  = word;
        res.log_id    = (ev != EV_NONE) ? cfg.alarm_id : '0;
        res.state_now = st;
        res.changed   = chg;
    end

endmodule
`default_nettype wire
